// ===== hdl/srt_tr_pkg.sv =====
// Shared types, character codes and digit weights for the timing line parser.
// No dependencies; every other file in hdl depends on this package.
package srt_tr_pkg;

  localparam int unsigned MS_W      = 29;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned WEIGHT_W  = 26;
  localparam int unsigned PROD_W    = WEIGHT_W + 4;
  localparam logic [POS_W-1:0] TOKEN_LEN = POS_W'(12);

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic {
    SIDE_LEFT,
    SIDE_RIGHT
  } side_t;

  typedef struct packed {
    logic [MS_W-1:0] start_ms;
    logic [MS_W-1:0] end_ms;
    logic            line_valid;
  } range_t;

  // Milliseconds contributed by one unit of the digit at a token offset.
  function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [POS_W-1:0] pos);
    logic [WEIGHT_W-1:0] w;
    unique case (pos)
      POS_W'(0):  w = WEIGHT_W'(36000000);
      POS_W'(1):  w = WEIGHT_W'(3600000);
      POS_W'(3):  w = WEIGHT_W'(600000);
      POS_W'(4):  w = WEIGHT_W'(60000);
      POS_W'(6):  w = WEIGHT_W'(10000);
      POS_W'(7):  w = WEIGHT_W'(1000);
      POS_W'(9):  w = WEIGHT_W'(100);
      POS_W'(10): w = WEIGHT_W'(10);
      POS_W'(11): w = WEIGHT_W'(1);
      default:    w = '0;
    endcase
    return w;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

endpackage

// ===== hdl/srt_tr_if.sv =====
// Valid/ready channel interfaces for line bytes in and parsed ranges out.
// Depends on srt_tr_pkg for the millisecond width.
interface srt_tr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_last;

  modport source (output valid, output line_byte, output line_last, input ready);
  modport sink   (input valid, input line_byte, input line_last, output ready);
endinterface

interface srt_tr_range_if;
  logic                        valid;
  logic                        ready;
  logic [srt_tr_pkg::MS_W-1:0] start_ms;
  logic [srt_tr_pkg::MS_W-1:0] end_ms;
  logic                        line_valid;

  modport source (output valid, output start_ms, output end_ms, output line_valid,
                  input ready);
  modport sink   (input valid, input start_ms, input end_ms, input line_valid,
                  output ready);
endinterface

// ===== hdl/srt_tr_parse.sv =====
// Per-byte parser state and the combinational range result for a closing byte.
// Depends on srt_tr_pkg.
module srt_tr_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         line_byte,
  input  logic               line_last,
  output srt_tr_pkg::range_t result
);
  import srt_tr_pkg::*;

  side_t              side, side_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [1:0]         dashes, dashes_next;
  logic               started, started_next;
  logic               closed, closed_next;
  logic               err, err_next;
  logic [MS_W-1:0]    start_total, start_total_next;
  logic [MS_W-1:0]    running, running_next;

  logic               take;
  logic [3:0]         digit;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  sum;
  logic               good;

  assign digit = 4'(line_byte - CHAR_ZERO);
  assign prod  = PROD_W'(digit_weight(pos)) * PROD_W'(digit);
  assign sum   = PROD_W'(running) + prod;

  // Next state for one accepted byte, before the end-of-line clear.
  always_comb begin
    side_next        = side;
    pos_next         = pos;
    dashes_next      = dashes;
    started_next     = started;
    closed_next      = closed;
    err_next         = err;
    start_total_next = start_total;
    running_next     = running;
    take             = 1'b0;

    if (side == SIDE_LEFT) begin
      if (line_byte == CHAR_DASH) begin
        // up to two dashes stay pending; a third flags an error
        if (dashes == 2'd2) err_next = 1'b1;
        else dashes_next = dashes + 2'd1;
      end else if (line_byte == CHAR_GT && dashes == 2'd2) begin
        if (pos != TOKEN_LEN) err_next = 1'b1;
        start_total_next = running;
        running_next     = '0;
        pos_next         = '0;
        dashes_next      = '0;
        started_next     = 1'b0;
        closed_next      = 1'b0;
        side_next        = SIDE_RIGHT;
      end else begin
        if (dashes != 2'd0) err_next = 1'b1;
        dashes_next = '0;
        take        = 1'b1;
      end
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (is_space(line_byte)) begin
        if (started) closed_next = 1'b1;
      end else if (closed || pos >= TOKEN_LEN) begin
        err_next = 1'b1;
      end else begin
        started_next = 1'b1;
        pos_next     = pos + POS_W'(1);
        if (pos == POS_W'(2) || pos == POS_W'(5)) begin
          if (line_byte != CHAR_COLON) err_next = 1'b1;
        end else if (pos == POS_W'(8)) begin
          if (line_byte != CHAR_COMMA) err_next = 1'b1;
        end else if (line_byte >= CHAR_ZERO && line_byte <= CHAR_NINE) begin
          running_next = sum[MS_W-1:0];
        end else begin
          err_next = 1'b1;
        end
      end
    end
  end

  // Result seen on the closing byte of a line.
  always_comb begin
    good = !err_next && side_next == SIDE_RIGHT && pos_next == TOKEN_LEN &&
           running_next >= start_total_next;
    result.line_valid = good;
    result.start_ms   = good ? start_total_next : '0;
    result.end_ms     = good ? running_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && line_last)) begin
      side        <= SIDE_LEFT;
      pos         <= '0;
      dashes      <= '0;
      started     <= 1'b0;
      closed      <= 1'b0;
      err         <= 1'b0;
      start_total <= '0;
      running     <= '0;
    end else if (accept) begin
      side        <= side_next;
      pos         <= pos_next;
      dashes      <= dashes_next;
      started     <= started_next;
      closed      <= closed_next;
      err         <= err_next;
      start_total <= start_total_next;
      running     <= running_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst) pos <= TOKEN_LEN)
    else $error("token position ran past twelve");
  a_line_clear: assert property (@(posedge clk) disable iff (rst)
      accept && line_last |=> side == SIDE_LEFT && pos == '0 && !err && running == '0)
    else $error("state not cleared after line end");
  a_right_no_dash: assert property (@(posedge clk) disable iff (rst)
      side == SIDE_RIGHT |-> dashes == 2'd0)
    else $error("dashes pending on right side");

endmodule

// ===== hdl/srt_tr_outbuf.sv =====
// Two-entry result buffer: output register plus a skid entry, so bytes keep
// flowing while a finished range waits. Depends on srt_tr_pkg.
module srt_tr_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  srt_tr_pkg::range_t push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output srt_tr_pkg::range_t out_data
);
  import srt_tr_pkg::*;

  logic   main_valid, skid_valid;
  range_t main_data, skid_data;
  logic   pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_data  <= skid_data;
        skid_valid <= push;
        if (push) skid_data <= push_data;
      end else begin
        main_valid <= push;
        if (push) main_data <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
      skid_valid |-> main_valid)
    else $error("skid entry holds a request ahead of the output register");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
      !(push && skid_valid))
    else $error("request pushed into a full buffer");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
      main_valid && !out_ready |=> main_valid && $stable(main_data))
    else $error("stalled result changed");

endmodule

// ===== hdl/srt_time_range_parser.sv =====
// Top level of the timing line parser: byte channel in, range channel out.
// Depends on srt_tr_pkg, srt_tr_if, srt_tr_parse and srt_tr_outbuf.
//
// Takes one byte of a "HH:MM:SS,mmm --> HH:MM:SS,mmm" line per cycle while
// ready is high, with line_last on the final byte, and returns one range
// request per line: start and end in milliseconds and line_valid (both times
// zero when invalid). Each byte is folded into the parser registers in the
// cycle it is accepted, one digit-weight multiply and add per byte; the range
// is registered into the output register, or into the skid entry while an
// earlier range waits. The two-entry output buffer lets the byte stream go on
// while a range waits, so ready drops only when two ranges are waiting unread.
module srt_time_range_parser (
  input  logic clk,
  input  logic rst,
  srt_tr_byte_if.sink    line_in,
  srt_tr_range_if.source range_out
);
  import srt_tr_pkg::*;

  logic   space;
  logic   accept;
  range_t parsed;
  range_t held;

  assign line_in.ready = space;
  assign accept        = line_in.valid && space;

  srt_tr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .line_byte (line_in.line_byte),
    .line_last (line_in.line_last),
    .result    (parsed)
  );

  srt_tr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && line_in.line_last),
    .push_data (parsed),
    .space     (space),
    .out_valid (range_out.valid),
    .out_ready (range_out.ready),
    .out_data  (held)
  );

  assign range_out.start_ms   = held.start_ms;
  assign range_out.end_ms     = held.end_ms;
  assign range_out.line_valid = held.line_valid;

endmodule
